// ----- hdl/lpf_pkg.sv -----
// shared types and constants for the lcd pixel fetch and palette block
`default_nettype none

package lpf_pkg;

    // operation codes
    localparam logic [2:0] OP_MEM_WRITE = 3'd0;
    localparam logic [2:0] OP_MEM_READ  = 3'd1;
    localparam logic [2:0] OP_PAL_ADDR  = 3'd2;
    localparam logic [2:0] OP_PAL_WRITE = 3'd3;
    localparam logic [2:0] OP_PAL_READ  = 3'd4;
    localparam logic [2:0] OP_FETCH     = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_LINE_UNITS    = 3'd0;
    localparam logic [2:0] CFG_DEPTH_SELECT  = 3'd1;
    localparam logic [2:0] CFG_COLOR_ENABLE  = 3'd2;
    localparam logic [2:0] CFG_DISPLAY_BLANK = 3'd3;
    localparam logic [2:0] CFG_SCREEN_START  = 3'd4;

    // configuration reset values
    localparam logic [6:0]  LINE_UNITS_RST   = 7'd3;
    localparam logic [1:0]  DEPTH_SELECT_RST = 2'd0;
    localparam logic        COLOR_ENABLE_RST = 1'b0;
    localparam logic        BLANK_RST        = 1'b0;
    localparam logic [15:0] SCREEN_START_RST = 16'd0;

    // pixel depth codes
    localparam logic [1:0] DEPTH_1BPP = 2'd0;
    localparam logic [1:0] DEPTH_2BPP = 2'd1;
    localparam logic [1:0] DEPTH_4BPP = 2'd2;
    localparam logic [1:0] DEPTH_8BPP = 2'd3;

    // palette component codes
    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    // palette geometry: one word holds red, green and blue nibbles
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_ADDR_W  = 8;
    localparam int PAL_WORD_W  = 12;

    // opaque alpha byte
    localparam logic [31:0] ARGB_ALPHA = 32'hff00_0000;

    // pixel fetch width: line index times line length plus column
    localparam int PIX_INDEX_W  = 20;
    localparam int FETCH_ADDR_W = 21;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MEM_RD,
        S_PAL_RD,
        S_ADDR,
        S_PIXEL,
        S_COLOR
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/lcd_pixel_fetch_palette.sv -----
// lcd pixel fetch core: video memory, palette memory and operation sequencer
// memory write, palette address write, unused codes and a blanked fetch finish
// in the exec state; memory read and palette data read or write add a read
// state, and a pixel fetch steps through addr, pixel and color. busy drops in
// the cycle of the done strobe, so a new transaction may start there. the path
// is set by the single video memory read and the palette memory read in turn.
// reset clears the sequencer, palette pointer, palette valid bits (palette reads
// as zero) and configuration; video memory content is undefined until written.
`default_nettype none

module lcd_pixel_fetch_palette #(
    parameter int MEMORY_BYTES = 81920
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command side
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  opcode,
    input  wire logic [16:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic [9:0]  pixel_x,
    input  wire logic [9:0]  pixel_y,
    // result side
    output logic             done,
    output logic [7:0]       read_data,
    output logic [31:0]      pixel_argb,
    output logic             out_of_range,
    // configuration port
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int ADDR_W = $clog2(MEMORY_BYTES);

    // sequencer and captured transaction
    lpf_pkg::state_t state_reg, state_next;
    logic [2:0]  op_reg;
    logic [16:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic [9:0]  x_reg;
    logic [9:0]  y_reg;

    // configuration
    logic [6:0]  line_units_reg;
    logic [1:0]  depth_select_reg;
    logic        color_enable_reg;
    logic        display_blank_reg;
    logic [15:0] screen_start_reg;

    // palette pointer and valid bits
    logic [7:0]  pal_address_reg, pal_address_next;
    logic [1:0]  pal_comp_reg, pal_comp_next;
    logic [lpf_pkg::PAL_ENTRIES-1:0] pal_valid_reg;

    // fetch pipeline registers
    logic [lpf_pkg::PIX_INDEX_W-1:0] pix_index_reg, pix_index_next;
    logic        range_ok_reg, range_ok_next;
    logic [2:0]  bit_off_reg, bit_off_next;
    logic [7:0]  pix_reg, pix_next;

    // result registers
    logic        done_reg, done_next;
    logic [7:0]  read_data_reg, read_data_next;
    logic [31:0] argb_reg, argb_next;
    logic        oor_reg, oor_next;

    // memory ports
    logic [7:0]  vmem [MEMORY_BYTES];
    logic        vmem_we;
    logic [ADDR_W-1:0] vmem_waddr;
    logic [ADDR_W-1:0] vmem_raddr;
    logic [7:0]  vmem_q_reg;

    logic [lpf_pkg::PAL_WORD_W-1:0] pal_mem [lpf_pkg::PAL_ENTRIES];
    logic        pal_we;
    logic [lpf_pkg::PAL_ADDR_W-1:0] pal_waddr;
    logic [lpf_pkg::PAL_ADDR_W-1:0] pal_raddr;
    logic [lpf_pkg::PAL_WORD_W-1:0] pal_wdata;
    logic [lpf_pkg::PAL_WORD_W-1:0] pal_q_reg;
    logic        pal_hit_reg;
    logic [lpf_pkg::PAL_WORD_W-1:0] pal_word;

    // fetch address arithmetic
    logic [7:0]  line_count;
    logic [10:0] per_line;
    logic [20:0] line_product;
    logic [lpf_pkg::PIX_INDEX_W-1:0] pix_index_calc;
    logic [1:0]  byte_shift;
    logic [lpf_pkg::FETCH_ADDR_W-1:0] byte_offset;
    logic [lpf_pkg::FETCH_ADDR_W-1:0] fetch_addr;
    logic        fetch_in_range;
    logic        access_in_range;
    logic [7:0]  shifted_byte;
    logic [7:0]  grey;

    // pixel index: row times line length plus column
    assign line_count     = {1'b0, line_units_reg} + 8'd1;
    assign per_line       = {line_count, 3'b000};
    assign line_product   = y_reg * per_line;
    assign pix_index_calc = line_product[lpf_pkg::PIX_INDEX_W-1:0]
                            + {10'd0, x_reg};

    // byte address of the pixel and range check
    assign byte_shift     = 2'd3 - depth_select_reg;
    assign byte_offset    = {1'b0, pix_index_reg} >> byte_shift;
    assign fetch_addr     = {4'd0, screen_start_reg, 1'b0} + byte_offset;
    assign fetch_in_range = fetch_addr < lpf_pkg::FETCH_ADDR_W'(MEMORY_BYTES);

    // direct memory access range check
    assign access_in_range = {1'b0, addr_reg} < 18'(MEMORY_BYTES);

    // palette word, unwritten entries read as zero
    assign pal_word     = pal_hit_reg ? pal_q_reg : '0;
    assign shifted_byte = vmem_q_reg >> bit_off_reg;

    // grey level from the pixel value by depth
    always_comb
    begin
        case (depth_select_reg)
            lpf_pkg::DEPTH_1BPP: grey = {8{pix_reg[0]}};
            lpf_pkg::DEPTH_2BPP: grey = {4{pix_reg[1:0]}};
            lpf_pkg::DEPTH_4BPP: grey = {2{pix_reg[3:0]}};
            default:             grey = pix_reg;
        endcase
    end

    // next state, memory controls and results
    always_comb
    begin
        state_next       = state_reg;
        pal_address_next = pal_address_reg;
        pal_comp_next    = pal_comp_reg;
        pix_index_next   = pix_index_reg;
        range_ok_next    = range_ok_reg;
        bit_off_next     = bit_off_reg;
        pix_next         = pix_reg;
        done_next        = 1'b0;
        read_data_next   = read_data_reg;
        argb_next        = argb_reg;
        oor_next         = oor_reg;
        vmem_we          = 1'b0;
        vmem_waddr       = addr_reg[ADDR_W-1:0];
        vmem_raddr       = addr_reg[ADDR_W-1:0];
        pal_we           = 1'b0;
        pal_waddr        = pal_address_reg;
        pal_raddr        = pal_address_reg;
        pal_wdata        = pal_word;

        case (state_reg)
            lpf_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = lpf_pkg::S_EXEC;
                end
            end

            lpf_pkg::S_EXEC:
            begin
                case (op_reg)
                    lpf_pkg::OP_MEM_WRITE:
                    begin
                        vmem_we        = access_in_range;
                        state_next     = lpf_pkg::S_IDLE;
                        done_next      = 1'b1;
                        read_data_next = '0;
                        argb_next      = '0;
                        oor_next       = 1'b0;
                    end
                    lpf_pkg::OP_MEM_READ:
                    begin
                        range_ok_next = access_in_range;
                        state_next    = lpf_pkg::S_MEM_RD;
                    end
                    lpf_pkg::OP_PAL_ADDR:
                    begin
                        pal_address_next = wdata_reg;
                        pal_comp_next    = lpf_pkg::COMP_RED;
                        state_next       = lpf_pkg::S_IDLE;
                        done_next        = 1'b1;
                        read_data_next   = '0;
                        argb_next        = '0;
                        oor_next         = 1'b0;
                    end
                    lpf_pkg::OP_PAL_WRITE, lpf_pkg::OP_PAL_READ:
                    begin
                        state_next = lpf_pkg::S_PAL_RD;
                    end
                    lpf_pkg::OP_FETCH:
                    begin
                        if (display_blank_reg)
                        begin
                            state_next     = lpf_pkg::S_IDLE;
                            done_next      = 1'b1;
                            read_data_next = '0;
                            argb_next      = lpf_pkg::ARGB_ALPHA;
                            oor_next       = 1'b0;
                        end
                        else
                        begin
                            pix_index_next = pix_index_calc;
                            state_next     = lpf_pkg::S_ADDR;
                        end
                    end
                    default:
                    begin
                        state_next     = lpf_pkg::S_IDLE;
                        done_next      = 1'b1;
                        read_data_next = '0;
                        argb_next      = '0;
                        oor_next       = 1'b0;
                    end
                endcase
            end

            lpf_pkg::S_MEM_RD:
            begin
                state_next     = lpf_pkg::S_IDLE;
                done_next      = 1'b1;
                read_data_next = range_ok_reg ? vmem_q_reg : '0;
                argb_next      = '0;
                oor_next       = 1'b0;
            end

            lpf_pkg::S_PAL_RD:
            begin
                // read of one colour nibble; a palette write makes it a read-modify-write
                case (pal_comp_reg)
                    lpf_pkg::COMP_RED:
                    begin
                        pal_wdata      = {wdata_reg[7:4], pal_word[7:0]};
                        read_data_next = {4'd0, pal_word[11:8]};
                    end
                    lpf_pkg::COMP_GREEN:
                    begin
                        pal_wdata      = {pal_word[11:8], wdata_reg[7:4], pal_word[3:0]};
                        read_data_next = {4'd0, pal_word[7:4]};
                    end
                    default:
                    begin
                        pal_wdata      = {pal_word[11:4], wdata_reg[7:4]};
                        read_data_next = {4'd0, pal_word[3:0]};
                    end
                endcase
                if (op_reg == lpf_pkg::OP_PAL_WRITE)
                begin
                    pal_we         = 1'b1;
                    read_data_next = '0;
                end
                // step red, green, blue, then the next entry
                if (pal_comp_reg >= lpf_pkg::COMP_BLUE)
                begin
                    pal_comp_next    = lpf_pkg::COMP_RED;
                    pal_address_next = pal_address_reg + 8'd1;
                end
                else
                begin
                    pal_comp_next = pal_comp_reg + 2'd1;
                end
                state_next = lpf_pkg::S_IDLE;
                done_next  = 1'b1;
                argb_next  = '0;
                oor_next   = 1'b0;
            end

            lpf_pkg::S_ADDR:
            begin
                vmem_raddr    = fetch_addr[ADDR_W-1:0];
                range_ok_next = fetch_in_range;
                bit_off_next  = pix_index_reg[2:0] << depth_select_reg;
                state_next    = lpf_pkg::S_PIXEL;
            end

            lpf_pkg::S_PIXEL:
            begin
                case (depth_select_reg)
                    lpf_pkg::DEPTH_1BPP: pix_next = {7'd0, shifted_byte[0]};
                    lpf_pkg::DEPTH_2BPP: pix_next = {6'd0, shifted_byte[1:0]};
                    lpf_pkg::DEPTH_4BPP: pix_next = {4'd0, shifted_byte[3:0]};
                    default:             pix_next = shifted_byte;
                endcase
                if (!range_ok_reg)
                begin
                    pix_next = '0;
                end
                pal_raddr  = pix_next;
                state_next = lpf_pkg::S_COLOR;
            end

            lpf_pkg::S_COLOR:
            begin
                if (color_enable_reg)
                begin
                    argb_next = lpf_pkg::ARGB_ALPHA
                              | {8'd0, pal_word[11:8], pal_word[11:8],
                                 pal_word[7:4], pal_word[7:4],
                                 pal_word[3:0], pal_word[3:0]};
                end
                else
                begin
                    argb_next = lpf_pkg::ARGB_ALPHA | {8'd0, grey, grey, grey};
                end
                state_next     = lpf_pkg::S_IDLE;
                done_next      = 1'b1;
                read_data_next = '0;
                oor_next       = !range_ok_reg;
            end

            default:
            begin
                state_next = lpf_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lpf_pkg::S_IDLE;
            pal_address_reg <= '0;
            pal_comp_reg    <= lpf_pkg::COMP_RED;
            pal_valid_reg   <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pal_address_reg <= pal_address_next;
            pal_comp_reg    <= pal_comp_next;
            done_reg        <= done_next;
            if (pal_we)
            begin
                pal_valid_reg[pal_waddr] <= 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_units_reg    <= lpf_pkg::LINE_UNITS_RST;
            depth_select_reg  <= lpf_pkg::DEPTH_SELECT_RST;
            color_enable_reg  <= lpf_pkg::COLOR_ENABLE_RST;
            display_blank_reg <= lpf_pkg::BLANK_RST;
            screen_start_reg  <= lpf_pkg::SCREEN_START_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lpf_pkg::CFG_LINE_UNITS:    line_units_reg    <= cfg_data[6:0];
                lpf_pkg::CFG_DEPTH_SELECT:  depth_select_reg  <= cfg_data[1:0];
                lpf_pkg::CFG_COLOR_ENABLE:  color_enable_reg  <= cfg_data[0];
                lpf_pkg::CFG_DISPLAY_BLANK: display_blank_reg <= cfg_data[0];
                lpf_pkg::CFG_SCREEN_START:  screen_start_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // transaction capture and datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == lpf_pkg::S_IDLE && start)
        begin
            op_reg    <= opcode;
            addr_reg  <= address;
            wdata_reg <= write_data;
            x_reg     <= pixel_x;
            y_reg     <= pixel_y;
        end
        pix_index_reg <= pix_index_next;
        range_ok_reg  <= range_ok_next;
        bit_off_reg   <= bit_off_next;
        pix_reg       <= pix_next;
        read_data_reg <= read_data_next;
        argb_reg      <= argb_next;
        oor_reg       <= oor_next;
    end

    // video memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (vmem_we)
        begin
            vmem[vmem_waddr] <= wdata_reg;
        end
        vmem_q_reg <= vmem[vmem_raddr];
    end

    // palette memory, red/green/blue nibbles in one word
    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[pal_waddr] <= pal_wdata;
        end
        pal_q_reg   <= pal_mem[pal_raddr];
        pal_hit_reg <= pal_valid_reg[pal_raddr];
    end

    // outputs
    assign busy         = (state_reg != lpf_pkg::S_IDLE);
    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign pixel_argb   = argb_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the lcd pixel fetch and palette block
module testbench;
    import lpf_pkg::*;

    localparam int          MEM_BYTES       = 81920;
    localparam int          ADDR_MAX        = 131071;
    localparam int          PHASES          = 10;
    localparam int          ITEMS_PER_PHASE = 80;
    localparam logic [2:0]  OP_UNUSED_A     = 3'd6;
    localparam logic [2:0]  OP_UNUSED_B     = 3'd7;

    // one result transaction
    typedef struct packed {
        logic [7:0]  rd;
        logic [31:0] argb;
        logic        oor;
    } pixel_result_t;

    // predicts every transaction of the block and checks the results in order
    class pixel_scoreboard;
        logic [7:0]    vram [0:MEM_BYTES-1];
        logic [3:0]    red_tab [0:PAL_ENTRIES-1];
        logic [3:0]    green_tab [0:PAL_ENTRIES-1];
        logic [3:0]    blue_tab [0:PAL_ENTRIES-1];
        logic [7:0]    pal_addr;
        logic [1:0]    pal_comp;
        logic [6:0]    line_units;
        logic [1:0]    depth;
        logic          color_en;
        logic          blank;
        logic [15:0]   screen_start;
        pixel_result_t pending_results [$];
        int            mismatch_count;

        function new();
            for (int i = 0; i < PAL_ENTRIES; i++)
            begin
                red_tab[i]   = 4'h0;
                green_tab[i] = 4'h0;
                blue_tab[i]  = 4'h0;
            end
            pal_addr       = 8'h00;
            pal_comp       = COMP_RED;
            line_units     = LINE_UNITS_RST;
            depth          = DEPTH_SELECT_RST;
            color_en       = COLOR_ENABLE_RST;
            blank          = BLANK_RST;
            screen_start   = SCREEN_START_RST;
            mismatch_count = 0;
        endfunction

        function void set_config(input logic [2:0] idx, input logic [15:0] val);
            case (idx)
                CFG_LINE_UNITS:    line_units   = val[6:0];
                CFG_DEPTH_SELECT:  depth        = val[1:0];
                CFG_COLOR_ENABLE:  color_en     = val[0];
                CFG_DISPLAY_BLANK: blank        = val[0];
                CFG_SCREEN_START:  screen_start = val;
                default: ;
            endcase
        endfunction

        // byte address holding pixel (x, y) under the current geometry
        function int unsigned fetch_address(input logic [9:0] x, input logic [9:0] y);
            int unsigned lu;
            int unsigned ss;
            int unsigned idx;
            lu  = line_units;
            ss  = screen_start;
            idx = y * ((lu + 1) * 8) + x;
            return (ss << 1) + ((idx << depth) >> 3);
        endfunction

        // pixel color as argb, with the out-of-memory flag
        function logic [31:0] fetch_color(input logic [9:0] x, input logic [9:0] y,
                                          output logic oor);
            int unsigned lu;
            int unsigned idx;
            int unsigned baddr;
            int unsigned per_byte;
            int unsigned pix;
            int unsigned word;
            logic [7:0]  sel;
            oor = 1'b0;
            if (blank)
                return ARGB_ALPHA;
            lu    = line_units;
            idx   = y * ((lu + 1) * 8) + x;
            baddr = fetch_address(x, y);
            pix   = 0;
            if (baddr >= MEM_BYTES)
                oor = 1'b1;
            else
            begin
                per_byte = 8 >> depth;
                word     = vram[baddr];
                pix      = (word >> ((idx % per_byte) << depth)) & ((1 << (1 << depth)) - 1);
            end
            // palette nibbles are doubled up to full bytes
            if (color_en)
            begin
                sel = pix[7:0];
                return ARGB_ALPHA | {8'h00, red_tab[sel], red_tab[sel], green_tab[sel],
                                     green_tab[sel], blue_tab[sel], blue_tab[sel]};
            end
            case (depth)
                DEPTH_1BPP: return ARGB_ALPHA | (pix * 32'h00ff_ffff);
                DEPTH_2BPP: return ARGB_ALPHA | (pix * 32'h0055_5555);
                DEPTH_4BPP: return ARGB_ALPHA | (pix * 32'h0011_1111);
                default:    return ARGB_ALPHA | (pix * 32'h0001_0101);
            endcase
        endfunction

        // red, green, blue, then on to the next entry
        function void step_palette();
            if (pal_comp == COMP_BLUE)
            begin
                pal_comp = COMP_RED;
                pal_addr = pal_addr + 8'd1;
            end
            else
                pal_comp = pal_comp + 2'd1;
        endfunction

        function void note_command(input logic [2:0] op, input logic [16:0] addr,
                                   input logic [7:0] wd, input logic [9:0] px,
                                   input logic [9:0] py);
            pixel_result_t r;
            logic          oor_bit;
            r = '0;
            case (op)
                OP_MEM_WRITE:
                    if (addr < MEM_BYTES)
                        vram[addr] = wd;
                OP_MEM_READ:
                    if (addr < MEM_BYTES)
                        r.rd = vram[addr];
                OP_PAL_ADDR:
                begin
                    pal_addr = wd;
                    pal_comp = COMP_RED;
                end
                OP_PAL_WRITE:
                begin
                    case (pal_comp)
                        COMP_RED:   red_tab[pal_addr]   = wd[7:4];
                        COMP_GREEN: green_tab[pal_addr] = wd[7:4];
                        default:    blue_tab[pal_addr]  = wd[7:4];
                    endcase
                    step_palette();
                end
                OP_PAL_READ:
                begin
                    case (pal_comp)
                        COMP_RED:   r.rd = {4'h0, red_tab[pal_addr]};
                        COMP_GREEN: r.rd = {4'h0, green_tab[pal_addr]};
                        default:    r.rd = {4'h0, blue_tab[pal_addr]};
                    endcase
                    step_palette();
                end
                OP_FETCH:
                begin
                    r.argb = fetch_color(px, py, oor_bit);
                    r.oor  = oor_bit;
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(input logic [7:0] rd, input logic [31:0] argb,
                                   input logic oor);
            pixel_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with none expected: read_data %h pixel_argb %h oor %b",
                         $time, rd, argb, oor);
                return;
            end
            exp_r = pending_results.pop_front();
            if (rd !== exp_r.rd)
            begin
                mismatch_count++;
                $display("%0t: read_data expected %h actual %h", $time, exp_r.rd, rd);
            end
            if (argb !== exp_r.argb)
            begin
                mismatch_count++;
                $display("%0t: pixel_argb expected %h actual %h", $time, exp_r.argb, argb);
            end
            if (oor !== exp_r.oor)
            begin
                mismatch_count++;
                $display("%0t: out_of_range expected %b actual %b", $time, exp_r.oor, oor);
            end
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic [2:0]  opcode       = OP_MEM_WRITE;
    logic [16:0] address      = '0;
    logic [7:0]  write_data   = '0;
    logic [9:0]  pixel_x      = '0;
    logic [9:0]  pixel_y      = '0;
    logic        cfg_write    = 1'b0;
    logic [2:0]  cfg_index    = CFG_LINE_UNITS;
    logic [15:0] cfg_data     = '0;
    logic        busy;
    logic        done;
    logic [7:0]  read_data;
    logic [31:0] pixel_argb;
    logic        out_of_range;

    pixel_scoreboard sb;
    bit              vram_written [0:MEM_BYTES-1];
    int unsigned     written_list [$];
    int              useful_items = 0;
    bit              steady       = 1'b0;

    lcd_pixel_fetch_palette #(
        .MEMORY_BYTES(MEM_BYTES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .address      (address),
        .write_data   (write_data),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .done         (done),
        .read_data    (read_data),
        .pixel_argb   (pixel_argb),
        .out_of_range (out_of_range),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(read_data, pixel_argb, out_of_range);
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [16:0] rand_addr();
        return $urandom_range(0, ADDR_MAX);
    endfunction

    function automatic logic [9:0] rand_coord();
        return $urandom_range(0, 1023);
    endfunction

    // one command transaction, after a random gap unless steady is set
    task automatic send(input logic [2:0] op, input logic [16:0] addr, input logic [7:0] wd,
                        input logic [9:0] px, input logic [9:0] py);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        address    <= addr;
        write_data <= wd;
        pixel_x    <= px;
        pixel_y    <= py;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(op, addr, wd, px, py);
        if (op <= OP_FETCH && !(op == OP_MEM_WRITE && addr >= MEM_BYTES))
            useful_items++;
        if (op == OP_MEM_WRITE && addr < MEM_BYTES && !vram_written[addr])
        begin
            vram_written[addr] = 1'b1;
            written_list.push_back(addr);
        end
    endtask

    // fetch a pixel, writing its byte first if it was never written
    task automatic fetch_item(input logic [9:0] x, input logic [9:0] y);
        int unsigned baddr;
        baddr = sb.fetch_address(x, y);
        if (baddr < MEM_BYTES && !vram_written[baddr])
            send(OP_MEM_WRITE, baddr[16:0], rand_byte(), rand_coord(), rand_coord());
        send(OP_FETCH, rand_addr(), rand_byte(), x, y);
    endtask

    // read a written byte or one beyond memory
    task automatic read_item();
        logic [16:0] addr;
        if (written_list.size() == 0 || $urandom_range(0, 4) == 0)
            addr = $urandom_range(MEM_BYTES, ADDR_MAX);
        else
            addr = written_list[$urandom_range(0, written_list.size() - 1)];
        send(OP_MEM_READ, addr, rand_byte(), rand_coord(), rand_coord());
    endtask

    // drop start and wait until every result is in
    task automatic settle();
        start <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_config(idx, val);
        @(posedge clk);
    endtask

    task automatic program_config(input logic [6:0] lu, input logic [1:0] dep,
                                  input logic ce, input logic bl, input logic [15:0] ss);
        write_register(CFG_LINE_UNITS, {9'd0, lu});
        write_register(CFG_DEPTH_SELECT, {14'd0, dep});
        write_register(CFG_COLOR_ENABLE, {15'd0, ce});
        write_register(CFG_DISPLAY_BLANK, {15'd0, bl});
        write_register(CFG_SCREEN_START, ss);
        cfg_write <= 1'b0;
    endtask

    // one random sequence, mostly well formed
    task automatic random_transaction();
        int          pick;
        logic [7:0]  entry;
        logic [16:0] addr;
        logic [9:0]  y;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            if ($urandom_range(0, 9) == 0)
                addr = $urandom_range(MEM_BYTES, ADDR_MAX);
            else
                addr = $urandom_range(0, MEM_BYTES - 1);
            send(OP_MEM_WRITE, addr, rand_byte(), rand_coord(), rand_coord());
        end
        else if (pick < 32)
            read_item();
        else if (pick < 50)
        begin
            // palette entry access: address, then red, green and blue
            entry = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : rand_byte();
            send(OP_PAL_ADDR, rand_addr(), entry, rand_coord(), rand_coord());
            for (int i = 0; i < 3; i++)
                send((pick < 42) ? OP_PAL_WRITE : OP_PAL_READ, rand_addr(), rand_byte(),
                     rand_coord(), rand_coord());
        end
        else if (pick < 88)
        begin
            y = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : rand_coord();
            fetch_item(rand_coord(), y);
        end
        else if (pick < 96)
        begin
            case ($urandom_range(0, 2))
                0:       send(OP_PAL_ADDR, rand_addr(), rand_byte(), rand_coord(), rand_coord());
                1:       send(OP_PAL_WRITE, rand_addr(), rand_byte(), rand_coord(), rand_coord());
                default: send(OP_PAL_READ, rand_addr(), rand_byte(), rand_coord(), rand_coord());
            endcase
        end
        else
            send($urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B, rand_addr(), rand_byte(),
                 rand_coord(), rand_coord());
    endtask

    // main sequence
    initial
    begin
        int          target;
        int unsigned roll;
        logic [15:0] ss;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // memory edges, including writes and reads beyond the end
        send(OP_MEM_WRITE, 17'd0, 8'hff, rand_coord(), rand_coord());
        send(OP_MEM_WRITE, 17'd81919, 8'ha5, rand_coord(), rand_coord());
        send(OP_MEM_WRITE, 17'd81920, 8'h3c, rand_coord(), rand_coord());
        send(OP_MEM_WRITE, 17'h1ffff, 8'h00, rand_coord(), rand_coord());
        send(OP_MEM_READ, 17'd0, rand_byte(), rand_coord(), rand_coord());
        send(OP_MEM_READ, 17'd81919, rand_byte(), rand_coord(), rand_coord());
        send(OP_MEM_READ, 17'h1ffff, rand_byte(), rand_coord(), rand_coord());
        fetch_item(10'd0, 10'd0);
        fetch_item(10'd1, 10'd0);

        // palette: low nibble dropped, address wrap after the last entry
        send(OP_PAL_ADDR, rand_addr(), 8'hff, rand_coord(), rand_coord());
        send(OP_PAL_WRITE, rand_addr(), 8'hff, rand_coord(), rand_coord());
        send(OP_PAL_WRITE, rand_addr(), 8'h0f, rand_coord(), rand_coord());
        send(OP_PAL_WRITE, rand_addr(), 8'h80, rand_coord(), rand_coord());
        send(OP_PAL_WRITE, rand_addr(), 8'h50, rand_coord(), rand_coord());
        send(OP_PAL_ADDR, rand_addr(), 8'hff, rand_coord(), rand_coord());
        repeat (4) send(OP_PAL_READ, rand_addr(), rand_byte(), rand_coord(), rand_coord());

        // address write mid-entry goes back to red
        send(OP_PAL_ADDR, rand_addr(), 8'h01, rand_coord(), rand_coord());
        send(OP_PAL_WRITE, rand_addr(), 8'h10, rand_coord(), rand_coord());
        send(OP_PAL_ADDR, rand_addr(), 8'h01, rand_coord(), rand_coord());
        send(OP_PAL_READ, rand_addr(), rand_byte(), rand_coord(), rand_coord());
        send(OP_UNUSED_A, rand_addr(), rand_byte(), rand_coord(), rand_coord());
        send(OP_UNUSED_B, rand_addr(), rand_byte(), rand_coord(), rand_coord());

        // last byte of memory and the first byte past it
        settle();
        program_config(7'd127, DEPTH_8BPP, 1'b0, 1'b0, 16'd0);
        fetch_item(10'd1023, 10'd79);
        fetch_item(10'd0, 10'd80);

        // random phases under several settings
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: program_config(7'd0, DEPTH_1BPP, 1'b0, 1'b0, 16'd0);
                1: program_config(7'd127, DEPTH_8BPP, 1'b1, 1'b0, 16'd0);
                2: program_config(7'd3, DEPTH_2BPP, 1'b0, 1'b0, 16'hffff);
                3: program_config(7'd127, DEPTH_4BPP, 1'b1, 1'b1, 16'd40000);
                default:
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70)
                        ss = $urandom_range(0, 2047);
                    else if (roll < 85)
                        ss = $urandom_range(0, 65535);
                    else
                        ss = $urandom_range(40000, 40959);
                    program_config($urandom_range(0, 127), $urandom_range(0, 3),
                                   $urandom_range(0, 1), $urandom_range(0, 4) == 0, ss);
                end
            endcase
            steady = (p == 1) || ($urandom_range(0, 2) == 0);
            target = useful_items + ITEMS_PER_PHASE;
            while (useful_items < target)
                random_transaction();
        end

        settle();
        repeat (8) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/lpf_pkg.sv
hdl/lcd_pixel_fetch_palette.sv
tb/sv/testbench.sv
